// ===== rtl/go_to_point_pid_controller_defines.svh =====
// Assertion macros used by the go-to-point controller port checker.
`ifndef GO_TO_POINT_PID_CONTROLLER_DEFINES_SVH
`define GO_TO_POINT_PID_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gtp_pkg.sv =====
// Types, constants and helper functions of the go-to-point controller.
`default_nettype none
package gtp_pkg;

  localparam int PosW  = 32;
  localparam int AngW  = 15;
  localparam int GainW = 24;
  localparam int AlimW = 14;
  localparam int ErrW  = 18;
  localparam int DistW = 33;
  localparam int DintW = 47;
  localparam int AccW  = 74;
  localparam int CordW = 44;
  localparam int ZW    = 20;

  localparam logic signed [ErrW-1:0] PI_Q12     = 18'sd12868;
  localparam logic signed [ErrW-1:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [ZW-1:0]   HALF_PI_Z  = 20'sd102944;

  localparam logic signed [PosW-1:0] PREV_XY_RST = 32'sd14746;
  localparam logic signed [15:0]     PREV_HD_RST = 16'sd6434;

  localparam logic [GainW-1:0] ROT_KP_RST  = 24'd655360;
  localparam logic [GainW-1:0] ROT_KI_RST  = 24'd655;
  localparam logic [GainW-1:0] LIN_KP_RST  = 24'd327680;
  localparam logic [GainW-1:0] LIN_KI_RST  = 24'd459;
  localparam logic [GainW-1:0] HEAD_KP_RST = 24'd1310720;
  localparam logic [GainW-1:0] HEAD_KI_RST = 24'd655;
  localparam logic [AlimW-1:0] ALIM_RST    = 14'd357;
  localparam logic [GainW-1:0] DLIM_RST    = 24'd3277;

  typedef enum logic [1:0] {
    MODE_ROT   = 2'd0,
    MODE_LIN   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_TURN  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_ROT_KP  = 3'd0,
    CFG_ROT_KI  = 3'd1,
    CFG_LIN_KP  = 3'd2,
    CFG_LIN_KI  = 3'd3,
    CFG_HEAD_KP = 3'd4,
    CFG_HEAD_KI = 3'd5,
    CFG_ALIM    = 3'd6,
    CFG_DLIM    = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_SQX    = 3'd0,
    MS_SQY    = 3'd1,
    MS_KP_E   = 3'd2,
    MS_KI_I   = 3'd3,
    MS_LKP_D  = 3'd4,
    MS_LKI_HI = 3'd5,
    MS_LKI_LO = 3'd6
  } mul_sel_t;

  typedef struct packed {
    logic     goal_ld;
    logic     tick_ld;
    logic     turn;
    logic     prep;
    logic     sinit;
    logic     iterate;
    logic     err;
    logic     decide;
    logic     rot_int;
    logic     lin_int;
    logic     mul_en;
    logic     mul_clr;
    mul_sel_t mul_sel;
    logic     ang_ld;
    logic     lin_ld;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic  turn_rot;
    logic  solve_done;
    mode_t dec_mode;
  } dp_status_t;

  function automatic logic signed [ErrW-1:0] wrap_ang(input logic signed [ErrW-1:0] a);
    logic signed [ErrW-1:0] r;
    if (a <= -PI_Q12) begin
      r = a + TWO_PI_Q12;
    end else if (a > PI_Q12) begin
      r = a - TWO_PI_Q12;
    end else begin
      r = a;
    end
    return r;
  endfunction

  // arctan(2^-i) in units of 2^-16 rad
  function automatic logic [16:0] atan_at(input logic [3:0] i);
    logic [16:0] r;
    unique case (i)
      4'd0:  r = 17'd51472;
      4'd1:  r = 17'd30386;
      4'd2:  r = 17'd16055;
      4'd3:  r = 17'd8150;
      4'd4:  r = 17'd4091;
      4'd5:  r = 17'd2047;
      4'd6:  r = 17'd1024;
      4'd7:  r = 17'd512;
      4'd8:  r = 17'd256;
      4'd9:  r = 17'd128;
      4'd10: r = 17'd64;
      4'd11: r = 17'd32;
      4'd12: r = 17'd16;
      4'd13: r = 17'd8;
      4'd14: r = 17'd4;
      4'd15: r = 17'd2;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gtp_ctrl.sv =====
// Sequencer of the go-to-point controller: one state per datapath step.
`default_nettype none
module gtp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  output logic                     in_ready,
  input  wire logic                out_ready,
  output logic                     out_valid,
  input  wire gtp_pkg::dp_status_t status,
  output gtp_pkg::dp_cmd_t         cmd
);
  import gtp_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_TURN   = 19'h00002,
    S_PREP   = 19'h00004,
    S_SQX    = 19'h00008,
    S_SQY    = 19'h00010,
    S_SINIT  = 19'h00020,
    S_SOLVE  = 19'h00040,
    S_ERR    = 19'h00080,
    S_DECIDE = 19'h00100,
    S_RI     = 19'h00200,
    S_M1     = 19'h00400,
    S_M2     = 19'h00800,
    S_ANG    = 19'h01000,
    S_LI     = 19'h02000,
    S_LM1    = 19'h04000,
    S_LM2    = 19'h08000,
    S_LM3    = 19'h10000,
    S_LV     = 19'h20000,
    S_EMIT   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MS_SQX;
    unique case (state_r)
      S_IDLE: begin
        cmd.goal_ld = in_valid && !in_kind;
        cmd.tick_ld = in_valid && in_kind;
        if (in_valid && in_kind) state_nxt = S_TURN;
      end
      S_TURN: begin
        cmd.turn  = 1'b1;
        state_nxt = status.turn_rot ? S_RI : S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sel = MS_SQX;
        state_nxt   = S_SQY;
      end
      S_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SQY;
        state_nxt   = S_SINIT;
      end
      S_SINIT: begin
        cmd.sinit = 1'b1;
        state_nxt = S_SOLVE;
      end
      S_SOLVE: begin
        cmd.iterate = 1'b1;
        if (status.solve_done) state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        unique case (status.dec_mode)
          MODE_ROT: state_nxt = S_RI;
          MODE_LIN: state_nxt = S_LI;
          default:  state_nxt = S_EMIT;
        endcase
      end
      S_RI: begin
        cmd.rot_int = 1'b1;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sel = MS_KP_E;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KI_I;
        state_nxt   = S_ANG;
      end
      S_ANG: begin
        cmd.ang_ld = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_LI: begin
        cmd.lin_int = 1'b1;
        state_nxt   = S_LM1;
      end
      S_LM1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sel = MS_LKP_D;
        state_nxt   = S_LM2;
      end
      S_LM2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LKI_HI;
        state_nxt   = S_LM3;
      end
      S_LM3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LKI_LO;
        state_nxt   = S_LV;
      end
      S_LV: begin
        cmd.lin_ld = 1'b1;
        state_nxt  = S_M1;
      end
      S_EMIT: begin
        // hold until the output register is free
        cmd.out_ld = emit_fire;
        if (emit_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gtp_dp.sv =====
// Datapath: goal state, integrators, square root, CORDIC bearing, PI multiplier.
`default_nettype none
module gtp_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_idx,
  input  wire logic [gtp_pkg::GainW-1:0]  cfg_wdata,
  input  wire logic signed [gtp_pkg::PosW-1:0] in_pos_x,
  input  wire logic signed [gtp_pkg::PosW-1:0] in_pos_y,
  input  wire logic signed [gtp_pkg::AngW-1:0] in_heading,
  input  wire gtp_pkg::dp_cmd_t           cmd,
  output gtp_pkg::dp_status_t             status,
  output logic signed [gtp_pkg::PosW-1:0] out_lin_vel,
  output logic signed [gtp_pkg::PosW-1:0] out_ang_vel,
  output logic [1:0]                      out_mode
);
  import gtp_pkg::*;

  localparam logic signed [CordW-1:0] Lim  = 44'sh0_8000_0000_00;
  localparam logic signed [CordW-1:0] Fit8 = Lim >>> 8;

  // configuration
  logic [GainW-1:0] rot_kp_r, rot_ki_r, lin_kp_r, lin_ki_r, head_kp_r, head_ki_r;
  logic [AlimW-1:0] alim_r;
  logic [GainW-1:0] dlim_r;

  // goal state
  logic signed [PosW-1:0] gx_r, gy_r, pgx_r, pgy_r;
  logic signed [15:0]     gh_r, pgh_r;
  logic                   same_r, other_r, turning_r;

  // integrators
  logic signed [PosW-1:0] rot_int_r, head_int_r;
  logic [DintW-1:0]       dint_r;

  // tick working registers
  logic signed [PosW-1:0] px_r, py_r;
  logic signed [AngW-1:0] hd_r;
  logic signed [ErrW-1:0] e_r;
  logic [DistW-1:0]       dist_r;
  logic [30:0]            ax_r, ay_r;
  logic                   half_r;
  mode_t                  mode_r;
  logic signed [PosW-1:0] lin_r, ang_r;

  // square root
  logic [63:0] sq_n_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [5:0]  sq_cnt_r;

  // CORDIC
  logic signed [CordW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]    cz_r;
  logic [4:0]              ci_r;
  logic                    cn_r;

  logic signed [AccW-1:0] acc_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_kp_r  <= ROT_KP_RST;
      rot_ki_r  <= ROT_KI_RST;
      lin_kp_r  <= LIN_KP_RST;
      lin_ki_r  <= LIN_KI_RST;
      head_kp_r <= HEAD_KP_RST;
      head_ki_r <= HEAD_KI_RST;
      alim_r    <= ALIM_RST;
      dlim_r    <= DLIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROT_KP:  rot_kp_r  <= cfg_wdata;
        CFG_ROT_KI:  rot_ki_r  <= cfg_wdata;
        CFG_LIN_KP:  lin_kp_r  <= cfg_wdata;
        CFG_LIN_KI:  lin_ki_r  <= cfg_wdata;
        CFG_HEAD_KP: head_kp_r <= cfg_wdata;
        CFG_HEAD_KI: head_ki_r <= cfg_wdata;
        CFG_ALIM:    alim_r    <= cfg_wdata[AlimW-1:0];
        CFG_DLIM:    dlim_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------- turn check
  logic                   turn_eff, clr_turn;
  logic signed [ErrW-1:0] e_turn;
  logic [ErrW-1:0]        e_turn_abs, e_abs;
  logic signed [ErrW-1:0] hd_ext;

  assign hd_ext     = {{(ErrW-AngW){hd_r[AngW-1]}}, hd_r};
  assign clr_turn   = same_r && other_r;
  assign turn_eff   = turning_r || clr_turn;
  assign e_turn     = wrap_ang({{(ErrW-16){gh_r[15]}}, gh_r} - hd_ext);
  assign e_turn_abs = e_turn[ErrW-1] ? ErrW'(-e_turn) : ErrW'(e_turn);
  assign e_abs      = e_r[ErrW-1] ? ErrW'(-e_r) : ErrW'(e_r);

  assign status.turn_rot = turn_eff && (e_turn_abs > {{(ErrW-AlimW){1'b0}}, alim_r});

  logic far, ang_big;
  assign far     = dist_r > {{(DistW-GainW){1'b0}}, dlim_r};
  assign ang_big = e_abs > {{(ErrW-AlimW){1'b0}}, alim_r};

  always_comb begin
    if (ang_big && far) begin
      status.dec_mode = MODE_ROT;
    end else if (far) begin
      status.dec_mode = MODE_LIN;
    end else begin
      status.dec_mode = MODE_CLOSE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r      <= '0;
      gy_r      <= '0;
      gh_r      <= '0;
      pgx_r     <= PREV_XY_RST;
      pgy_r     <= PREV_XY_RST;
      pgh_r     <= PREV_HD_RST;
      same_r    <= 1'b0;
      other_r   <= 1'b0;
      turning_r <= 1'b0;
    end else begin
      if (cmd.goal_ld) begin
        gx_r    <= in_pos_x;
        gy_r    <= in_pos_y;
        gh_r    <= {in_heading[AngW-1], in_heading};
        same_r  <= (in_pos_x == pgx_r) && (in_pos_y == pgy_r);
        other_r <= ({in_heading[AngW-1], in_heading} != pgh_r);
        pgx_r   <= in_pos_x;
        pgy_r   <= in_pos_y;
        pgh_r   <= {in_heading[AngW-1], in_heading};
      end
      if (cmd.turn) turning_r <= status.turn_rot;
    end
  end

  // ---------------------------------------------------------------- integrators
  logic signed [PosW:0]   rot_sum, head_sum;
  logic [DintW:0]         dint_sum;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW:0] v);
    logic signed [PosW-1:0] r;
    if (v[PosW] != v[PosW-1]) begin
      r = v[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

  assign rot_sum  = {rot_int_r[PosW-1], rot_int_r} + {{(PosW+1-ErrW){e_r[ErrW-1]}}, e_r};
  assign head_sum = {head_int_r[PosW-1], head_int_r} + {{(PosW+1-ErrW){e_r[ErrW-1]}}, e_r};
  assign dint_sum = {1'b0, dint_r} + {{(DintW+1-DistW){1'b0}}, dist_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_int_r  <= '0;
      head_int_r <= '0;
      dint_r     <= '0;
    end else begin
      if ((cmd.turn && clr_turn) || (cmd.decide && status.dec_mode == MODE_CLOSE)) begin
        rot_int_r  <= '0;
        head_int_r <= '0;
        dint_r     <= '0;
      end
      if (cmd.rot_int) rot_int_r <= sat32(rot_sum);
      if (cmd.lin_int) begin
        head_int_r <= sat32(head_sum);
        dint_r     <= dint_sum[DintW] ? {DintW{1'b1}} : dint_sum[DintW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- prepare
  logic signed [PosW:0] dx, dy;
  logic [PosW:0]        adx, ady;
  logic                 big, zero_vec;

  assign dx       = {gx_r[PosW-1], gx_r} - {px_r[PosW-1], px_r};
  assign dy       = {gy_r[PosW-1], gy_r} - {py_r[PosW-1], py_r};
  assign adx      = dx[PosW] ? (PosW+1)'(-dx) : (PosW+1)'(dx);
  assign ady      = dy[PosW] ? (PosW+1)'(-dy) : (PosW+1)'(dy);
  assign big      = adx[31] || ady[31];
  assign zero_vec = (dx == '0) && (dy == '0);

  // ---------------------------------------------------------------- multiplier
  logic signed [33:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [65:0]    prod;
  logic signed [AccW-1:0] addend;
  logic                  use_head;

  assign use_head = (mode_r == MODE_LIN);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_SQX: begin
        mul_a = {3'b000, ax_r};
        mul_b = {1'b0, ax_r};
      end
      MS_SQY: begin
        mul_a = {3'b000, ay_r};
        mul_b = {1'b0, ay_r};
      end
      MS_KP_E: begin
        mul_a = {{(34-ErrW){e_r[ErrW-1]}}, e_r};
        mul_b = {8'd0, use_head ? head_kp_r : rot_kp_r};
      end
      MS_KI_I: begin
        mul_a = use_head ? {{2{head_int_r[PosW-1]}}, head_int_r}
                         : {{2{rot_int_r[PosW-1]}}, rot_int_r};
        mul_b = {8'd0, use_head ? head_ki_r : rot_ki_r};
      end
      MS_LKP_D: begin
        mul_a = {1'b0, dist_r};
        mul_b = {8'd0, lin_kp_r};
      end
      MS_LKI_HI: begin
        mul_a = {11'd0, dint_r[DintW-1:24]};
        mul_b = {8'd0, lin_ki_r};
      end
      MS_LKI_LO: begin
        mul_a = {10'd0, dint_r[23:0]};
        mul_b = {8'd0, lin_ki_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign addend = (cmd.mul_sel == MS_LKI_HI) ? ({{(AccW-66){prod[65]}}, prod} <<< 24)
                                             : {{(AccW-66){prod[65]}}, prod};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) acc_r <= cmd.mul_clr ? addend : acc_r + addend;
  end

  // ---------------------------------------------------------------- square root
  logic [35:0] sq_tmp, sq_try, sq_dif;
  assign sq_tmp = {sq_rem_r, sq_n_r[63:62]};
  assign sq_try = {2'b00, sq_root_r, 2'b01};
  assign sq_dif = sq_tmp - sq_try;

  // ---------------------------------------------------------------- CORDIC
  logic signed [CordW-1:0] cx_sh, cy_sh;
  logic                    fit8, fitl;
  logic signed [ZW-1:0]    atan_z;

  assign cx_sh  = cx_r >>> ci_r[3:0];
  assign cy_sh  = cy_r >>> ci_r[3:0];
  assign fit8   = (cx_r < Fit8) && (cx_r > -Fit8) && (cy_r < Fit8) && (cy_r > -Fit8);
  assign fitl   = (cx_r < Lim) && (cx_r > -Lim) && (cy_r < Lim) && (cy_r > -Lim);
  assign atan_z = {3'b000, atan_at(ci_r[3:0])};

  assign status.solve_done = sq_cnt_r[5] && !cn_r && ci_r[4];

  // ---------------------------------------------------------------- bearing error
  logic signed [ZW-1:0]   bz;
  logic signed [ErrW-1:0] bear, e_nav;
  assign bz    = (cz_r + 20'sd8) >>> 4;
  assign bear  = wrap_ang(bz[ErrW-1:0]);
  assign e_nav = wrap_ang(bear - hd_ext);

  // ---------------------------------------------------------------- output shaping
  logic signed [AccW-1:0] acc_sh;
  logic signed [PosW-1:0] ang_sat, lin_sat;
  assign acc_sh = acc_r >>> 12;

  always_comb begin
    if ((acc_sh[AccW-1:31] == '0) || (acc_sh[AccW-1:31] == '1)) begin
      ang_sat = acc_sh[31:0];
    end else begin
      ang_sat = acc_sh[AccW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
    // distance terms are never negative
    if (acc_r[AccW-1:47] != '0) begin
      lin_sat = {1'b0, {31{1'b1}}};
    end else begin
      lin_sat = acc_r[47:16];
    end
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (cmd.tick_ld) begin
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      hd_r  <= in_heading;
      lin_r <= '0;
      ang_r <= '0;
    end
    if (cmd.turn) begin
      e_r    <= e_turn;
      mode_r <= MODE_TURN;
    end
    if (cmd.prep) begin
      half_r <= big;
      ax_r   <= big ? adx[31:1] : adx[30:0];
      ay_r   <= big ? ady[31:1] : ady[30:0];
      ci_r   <= zero_vec ? 5'd16 : 5'd0;
      cn_r   <= !zero_vec;
      if (zero_vec || !dx[PosW]) begin
        cx_r <= {{(CordW-PosW-1){dx[PosW]}}, dx};
        cy_r <= {{(CordW-PosW-1){dy[PosW]}}, dy};
        cz_r <= '0;
      end else if (!dy[PosW]) begin
        cx_r <= {{(CordW-PosW-1){dy[PosW]}}, dy};
        cy_r <= -{{(CordW-PosW-1){dx[PosW]}}, dx};
        cz_r <= HALF_PI_Z;
      end else begin
        cx_r <= -{{(CordW-PosW-1){dy[PosW]}}, dy};
        cy_r <= {{(CordW-PosW-1){dx[PosW]}}, dx};
        cz_r <= -HALF_PI_Z;
      end
    end
    if (cmd.sinit) begin
      sq_n_r    <= acc_r[63:0];
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end
    if (cmd.iterate) begin
      if (!sq_cnt_r[5]) begin
        sq_n_r   <= {sq_n_r[61:0], 2'b00};
        sq_cnt_r <= sq_cnt_r + 6'd1;
        if (sq_tmp >= sq_try) begin
          sq_rem_r  <= sq_dif[33:0];
          sq_root_r <= {sq_root_r[30:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_tmp[33:0];
          sq_root_r <= {sq_root_r[30:0], 1'b0};
        end
      end
      if (cn_r) begin
        // scale up the vector before the rotations
        if (fit8) begin
          cx_r <= cx_r <<< 8;
          cy_r <= cy_r <<< 8;
        end else if (fitl) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end else begin
          cn_r <= 1'b0;
        end
      end else if (!ci_r[4]) begin
        ci_r <= ci_r + 5'd1;
        if (!cy_r[CordW-1]) begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + atan_z;
        end else begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - atan_z;
        end
      end
    end
    if (cmd.err) begin
      dist_r <= half_r ? {sq_root_r, 1'b0} : {1'b0, sq_root_r};
      e_r    <= e_nav;
    end
    if (cmd.decide) mode_r <= status.dec_mode;
    if (cmd.ang_ld) ang_r <= ang_sat;
    if (cmd.lin_ld) lin_r <= lin_sat;
    if (cmd.out_ld) begin
      out_lin_vel <= lin_r;
      out_ang_vel <= ang_r;
      out_mode    <= mode_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/go_to_point_pid_controller.sv =====
// Top level of the go-to-point PI controller for a differential-drive robot.
// A goal item (tuser 0) is taken and gives no result. A control tick (tuser 1)
// gives one velocity command. When stopping, rotating in place or driving
// forward, the result waits for the square root (32 steps) that runs alongside
// the shorter CORDIC bearing; while turning on the spot both are skipped. One
// tick is worked at a time; the result sits in an output register so the next
// item is taken while it waits, and a new result waits only if the previous one
// has not been taken yet.
`default_nettype none
module go_to_point_pid_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // pos_x[31:0], pos_y[63:32], heading[78:64]
  input  wire logic [0:0]  in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // lin_vel[31:0], ang_vel[63:32]
  output logic [1:0]       out_tuser,  // mode[1:0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata
);
  import gtp_pkg::*;

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic signed [PosW-1:0] lin_vel, ang_vel;

  gtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser[0]),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  gtp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_pos_x    (in_tdata[31:0]),
    .in_pos_y    (in_tdata[63:32]),
    .in_heading  (in_tdata[78:64]),
    .cmd         (cmd),
    .status      (status),
    .out_lin_vel (lin_vel),
    .out_ang_vel (ang_vel),
    .out_mode    (out_tuser)
  );

  assign out_tdata = {ang_vel, lin_vel};

endmodule
`default_nettype wire

// ===== rtl/gtp_chk.sv =====
// Port-level checker for the go-to-point controller, bound to the top level.
`default_nettype none
`include "go_to_point_pid_controller_defines.svh"
module gtp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import gtp_pkg::*;

  `GTP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")
  `GTP_ASSERT_NOW(a_close_zero, out_tvalid && out_tuser == MODE_CLOSE, out_tdata == '0, "stop command not zero")
  `GTP_ASSERT_NOW(a_rot_no_lin, out_tvalid && (out_tuser == MODE_ROT || out_tuser == MODE_TURN), out_tdata[31:0] == '0, "rotation with forward speed")
  `GTP_ASSERT_NEXT(a_goal_silent, in_tvalid && in_tready && !in_tuser[0], !$rose(out_tvalid), "goal item produced a result")

endmodule

bind go_to_point_pid_controller gtp_chk u_chk (.*);
`default_nettype wire

// ===== bench/gtp_checker.sv =====
// Checker for the go-to-point controller: predicts each velocity command and compares it.
`timescale 1ns / 100ps
`default_nettype none
module gtp_checker
  import gtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata,
  output int               errors,
  output int               pending,
  output int               n_checked,
  output int               n_turn,
  output int               n_drive
);

  typedef struct {
    logic [31:0] lin;
    logic [31:0] ang;
    mode_t       mode;
  } cmd_t;

  localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint DINT_SAT = 64'h7FFF_FFFF_FFFF;

  cmd_t cmd_q[$];

  longint unsigned g_rot_kp, g_rot_ki, g_lin_kp, g_lin_ki, g_head_kp, g_head_ki;
  longint unsigned g_alim, g_dlim;
  longint gx, gy, gh, pgx, pgy, pgh;
  bit same_pt, new_hd, turning;
  longint rot_acc, head_acc;
  longint unsigned dist_acc;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap_pi(longint a);
    if (a <= -12868) return a + 25736;
    if (a > 12868) return a - 25736;
    return a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_bearing(longint x, longint y);
    longint z, t, xs, ys, lim;
    lim = 64'sd1 <<< 39;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    while (x < lim && x > -lim && y < lim && y > -lim) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
      end
    end
    return wrap_pi((z + 8) >>> 4);
  endfunction

  function automatic longint rot_pi(longint e);
    rot_acc = clip32(rot_acc + e);
    return clip32((longint'(g_rot_kp) * e + longint'(g_rot_ki) * rot_acc) >>> 12);
  endfunction

  function automatic void clear_acc();
    rot_acc = 0;
    head_acc = 0;
    dist_acc = 0;
  endfunction

  // Update controller state for one tick and return the command it gives.
  function automatic cmd_t steer_tick(longint px, longint py, longint hd);
    cmd_t c;
    longint e, dx, dy, lin, ang;
    longint unsigned ax, ay, dist_v, p, hi, lo, ih, il, v;
    lin = 0;
    ang = 0;
    if (same_pt && new_hd) begin
      turning = 1;
      clear_acc();
    end
    if (turning) begin
      e = wrap_pi(gh - hd);
      if (longint'(e < 0 ? -e : e) > longint'(g_alim)) begin
        ang = rot_pi(e);
        c.lin = '0;
        c.ang = ang[31:0];
        c.mode = MODE_TURN;
        return c;
      end
      turning = 0;
    end
    dx = gx - px;
    dy = gy - py;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax < (64'd1 << 31) && ay < (64'd1 << 31)) begin
      dist_v = int_sqrt(ax * ax + ay * ay);
    end else begin
      ax = ax >> 1;
      ay = ay >> 1;
      dist_v = int_sqrt(ax * ax + ay * ay) << 1;
    end
    e = wrap_pi(cordic_bearing(dx, dy) - hd);
    if (longint'(e < 0 ? -e : e) > longint'(g_alim) && dist_v > g_dlim) begin
      ang = rot_pi(e);
      c.mode = MODE_ROT;
    end else if (dist_v > g_dlim) begin
      dist_acc = dist_acc + dist_v;
      if (dist_acc > DINT_SAT) dist_acc = DINT_SAT;
      p  = g_lin_kp * dist_v;
      hi = dist_acc >> 24;
      lo = dist_acc & 64'hFF_FFFF;
      ih = g_lin_ki * hi;
      il = g_lin_ki * lo;
      v  = (p >> 16) + (ih << 8) + (il >> 16) + (((p & 64'hFFFF) + (il & 64'hFFFF)) >> 16);
      lin = v > 64'd2147483647 ? 64'sd2147483647 : longint'(v);
      head_acc = clip32(head_acc + e);
      ang = clip32((longint'(g_head_kp) * e + longint'(g_head_ki) * head_acc) >>> 12);
      c.mode = MODE_LIN;
    end else begin
      clear_acc();
      c.mode = MODE_CLOSE;
    end
    c.lin = lin[31:0];
    c.ang = ang[31:0];
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_t exp_c, got;
    longint px, py, hd;
    if (!rst_n) begin
      g_rot_kp = ROT_KP_RST; g_rot_ki = ROT_KI_RST;
      g_lin_kp = LIN_KP_RST; g_lin_ki = LIN_KI_RST;
      g_head_kp = HEAD_KP_RST; g_head_ki = HEAD_KI_RST;
      g_alim = ALIM_RST; g_dlim = DLIM_RST;
      gx = 0; gy = 0; gh = 0;
      pgx = 14746; pgy = 14746; pgh = 6434;
      same_pt = 0; new_hd = 0; turning = 0;
      clear_acc();
      cmd_q.delete();
      errors <= 0;
      n_checked <= 0;
      n_turn <= 0;
      n_drive <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_ROT_KP:  g_rot_kp  = cfg_wdata;
          CFG_ROT_KI:  g_rot_ki  = cfg_wdata;
          CFG_LIN_KP:  g_lin_kp  = cfg_wdata;
          CFG_LIN_KI:  g_lin_ki  = cfg_wdata;
          CFG_HEAD_KP: g_head_kp = cfg_wdata;
          CFG_HEAD_KI: g_head_ki = cfg_wdata;
          CFG_ALIM:    g_alim    = cfg_wdata[13:0];
          CFG_DLIM:    g_dlim    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.lin = out_tdata[31:0];
        got.ang = out_tdata[63:32];
        got.mode = mode_t'(out_tuser);
        n_checked <= n_checked + 1;
        if (got.mode == MODE_TURN) n_turn <= n_turn + 1;
        if (got.mode == MODE_LIN) n_drive <= n_drive + 1;
        if (cmd_q.size() == 0) begin
          if (errors < 10) $display("unexpected command: lin %h ang %h mode %0d",
                                    got.lin, got.ang, got.mode);
          errors <= errors + 1;
        end else begin
          exp_c = cmd_q.pop_front();
          if (got.lin !== exp_c.lin || got.ang !== exp_c.ang || got.mode !== exp_c.mode) begin
            if (errors < 10)
              $display("command %0d: expected lin %h ang %h mode %0d, got lin %h ang %h mode %0d",
                       n_checked, exp_c.lin, exp_c.ang, exp_c.mode,
                       got.lin, got.ang, got.mode);
            errors <= errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        px = longint'($signed(in_tdata[31:0]));
        py = longint'($signed(in_tdata[63:32]));
        hd = longint'($signed(in_tdata[78:64]));
        if (in_tuser[0] == 1'b0) begin
          gx = px; gy = py; gh = hd;
          same_pt = (gx == pgx) && (gy == pgy);
          new_hd = (gh != pgh);
          pgx = gx; pgy = gy; pgh = gh;
        end else begin
          cmd_q.push_back(steer_tick(px, py, hd));
        end
      end
    end
    pending <= cmd_q.size();
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench top: clock, reset, stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gtp_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 1330;
  localparam int NUM_PHASES = 7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_wdata;

  int errors, pending, n_checked, n_turn, n_drive;
  int cycles;
  int n_sent;
  bit calm;

  // Goal as the stimulus side last sent it
  int gx, gy, gh;

  go_to_point_pid_controller u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .cfg_we, .cfg_idx, .cfg_wdata
  );

  gtp_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .cfg_we, .cfg_idx, .cfg_wdata,
    .errors, .pending, .n_checked, .n_turn, .n_drive
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: stall a random number of cycles before each command
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(bit kind, int x, int y, int h);
    int n;
    n = calm ? 0 : $urandom_range(0, 19);
    if (n > 0) begin
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {1'b0, h[14:0], y, x};
    do @(posedge clk); while (!in_tready);
    if (kind == 1'b0) begin
      gx = x; gy = y; gh = $signed(h[14:0]);
    end
    n_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic int offset(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Heading that points from (x, y) at the goal, plus a little noise
  function automatic int aim_heading(int x, int y, int noise);
    real b;
    b = $atan2(real'(longint'(gy) - y), real'(longint'(gx) - x));
    return int'(b * 4096.0) + offset(noise);
  endfunction

  task automatic random_item();
    int r, x, y, h, sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        // same point, new heading: turn on the spot
        send_item(0, gx, gy, offset(12868));
      end else if (r < 5) begin
        send_item(0, $urandom, $urandom, $urandom_range(0, 32767));
      end else begin
        send_item(0, offset(1 << 20), offset(1 << 20), offset(12868));
      end
    end else begin
      r = $urandom_range(0, 19);
      case ($urandom_range(0, 3))
        0: r = 100;
        1: r = 4000;
        2: r = 1 << 18;
        default: r = 1 << 22;
      endcase
      x = gx + offset(r);
      y = gy + offset(r);
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        x = $urandom;
        y = $urandom;
        h = $urandom_range(0, 32767);
      end else if (sel < 50) begin
        h = aim_heading(x, y, 300);
      end else if (sel < 65) begin
        h = gh + offset(500);
      end else begin
        h = offset(12868);
      end
      send_item(1, x, y, h);
    end
  endtask

  task automatic set_phase(int p);
    case (p)
      1: begin
        write_reg(CFG_ROT_KP, 24'hFFFFFF);  write_reg(CFG_ROT_KI, 24'hFFFFFF);
        write_reg(CFG_LIN_KP, 24'hFFFFFF);  write_reg(CFG_LIN_KI, 24'hFFFFFF);
        write_reg(CFG_HEAD_KP, 24'hFFFFFF); write_reg(CFG_HEAD_KI, 24'hFFFFFF);
        write_reg(CFG_ALIM, 24'h003FFF);    write_reg(CFG_DLIM, 24'hFFFFFF);
      end
      2: begin
        write_reg(CFG_ROT_KP, 24'd0);  write_reg(CFG_ROT_KI, 24'd0);
        write_reg(CFG_LIN_KP, 24'd0);  write_reg(CFG_LIN_KI, 24'd0);
        write_reg(CFG_HEAD_KP, 24'd0); write_reg(CFG_HEAD_KI, 24'd0);
        write_reg(CFG_ALIM, 24'd0);    write_reg(CFG_DLIM, 24'd0);
      end
      3: begin
        write_reg(CFG_ROT_KP, 24'hFFFFFF);  write_reg(CFG_ROT_KI, 24'hFFFFFF);
        write_reg(CFG_LIN_KP, 24'hFFFFFF);  write_reg(CFG_LIN_KI, 24'hFFFFFF);
        write_reg(CFG_HEAD_KP, 24'hFFFFFF); write_reg(CFG_HEAD_KI, 24'hFFFFFF);
        write_reg(CFG_ALIM, 24'd12867);     write_reg(CFG_DLIM, 24'd0);
      end
      default: begin
        write_reg(CFG_ROT_KP, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_ROT_KI, 24'($urandom_range(0, 24'hFFFF)));
        write_reg(CFG_LIN_KP, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_LIN_KI, 24'($urandom_range(0, 24'hFFFF)));
        write_reg(CFG_HEAD_KP, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_HEAD_KI, 24'($urandom_range(0, 24'hFFFF)));
        write_reg(CFG_ALIM, 24'($urandom_range(0, 2000)));
        write_reg(CFG_DLIM, 24'($urandom_range(0, 20000)));
      end
    endcase
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    calm = 0;
    n_sent = 0;
    gx = 0; gy = 0; gh = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part under reset settings
    send_item(1, 0, 0, 0);                             // zero vector at reset goal
    send_item(0, 14746, 14746, 6434);                  // same point, same heading
    send_item(1, 0, 0, 16383);                         // heading out of range
    send_item(0, 14746, 14746, -12868);                // same point, other heading
    send_item(1, 14746, 14746, 12868);                 // wrap once
    send_item(1, 14746, 14746, -16384);
    send_item(1, 14746, 14746, -12868);                // turn finished
    send_item(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16383);
    send_item(1, 32'h80000000, 32'h80000000, -16384);  // large distance
    send_item(1, 32'h80000000, 32'h7FFFFFFF, 0);
    send_item(0, 32'h80000000, 32'h80000000, -16384);
    send_item(1, 32'h7FFFFFFF, 32'h80000000, 12868);
    send_item(0, 65536, 0, 0);
    send_item(1, 0, 0, 0);                             // drive straight
    send_item(1, 0, 0, 0);
    send_item(1, 65536, 1000, 0);                      // close enough
    send_item(1, 65536, -65536, 6434);
    send_item(0, 0, 0, 1);
    send_item(0, 0, 0, 2);                             // same point twice
    send_item(1, -65536, 0, 0);
    send_item(1, 0, 0, 2);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) set_phase(p);
      for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
        if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
      end
      calm = 0;
      drain();
    end

    $display("sent %0d items, checked %0d commands over %0d settings", n_sent, n_checked,
             NUM_PHASES);
    $display("turn-on-spot %0d, translate %0d, %0d cycles", n_turn, n_drive, cycles);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d commands missing", errors, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
